// ----- rtl/sip_pkg.sv -----
// Package with the SipHash-2-4 constants, lane type, sequencer states and round function.
package sip_pkg;

    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 4;
    localparam int LEN_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    localparam logic [WORD_W-1:0] INIT_A    = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] INIT_B    = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] INIT_C    = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] INIT_D    = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD = 2'd2;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;
    localparam logic [LEN_W-1:0]   WORD_BYTES = 8'd8;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } lanes_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORD,
        ST_TAIL,
        ST_FINAL
    } sip_state_t;

    // One SipRound over the four lanes.
    function automatic lanes_t sip_round(input lanes_t v);
        lanes_t r;
        r = v;
        r.a = r.a + r.b;
        r.b = {r.b[50:0], r.b[63:51]} ^ r.a;
        r.a = {r.a[31:0], r.a[63:32]};
        r.c = r.c + r.d;
        r.d = {r.d[47:0], r.d[63:48]} ^ r.c;
        r.a = r.a + r.d;
        r.d = {r.d[42:0], r.d[63:43]} ^ r.a;
        r.c = r.c + r.b;
        r.b = {r.b[46:0], r.b[63:47]} ^ r.c;
        r.c = {r.c[31:0], r.c[63:32]};
        return r;
    endfunction

    // Maps ASCII 'A'..'Z' to lower case in each of the eight bytes.
    function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        logic [7:0]        b;
        r = w;
        for (int i = 0; i < 8; i++) begin
            b = w[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5a) begin
                r[8*i +: 8] = b + 8'h20;
            end
        end
        return r;
    endfunction

    // Keeps the first cnt bytes of a word, cnt in 0..7.
    function automatic logic [WORD_W-1:0] keep_bytes(input logic [WORD_W-1:0] w,
                                                    input logic [COUNT_W-1:0] cnt);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (COUNT_W'(i) < cnt) begin
                r[8*i +: 8] = w[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/siphash24_keyed_hash_core.sv -----
// Top level of the keyed SipHash-2-4 engine: stream ports, sequencer and shared round unit.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tdata = data_word, byte_count; s_tlast = last
//  m_        out        m_tvalid/m_tready  m_tdata = hash
//  cfg_wr_   in         cfg_wr_en          cfg_wr_index selects key_low, key_high, case_fold
//
// A single SipRound unit serves every round, one round per clock cycle but for a stall at
// the last finalization round, since the result sits in an output register. A word that
// is not last takes the transfer and two rounds. A last word takes the transfer, two
// tail rounds and four finalization rounds, after two word rounds if it has eight valid
// bytes. aresetn is synchronous and active low; it clears the sequencer, the message
// flag, the output valid and the configuration registers.
module siphash24_keyed_hash_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata fields from bit 0 up: data_word [63:0], byte_count [67:64], zero pad.
    input  logic [sip_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata fields from bit 0 up: hash [63:0].
    output logic [sip_pkg::M_TDATA_W-1:0]  m_tdata,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [sip_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [sip_pkg::WORD_W-1:0]     cfg_wr_data
);
    import sip_pkg::*;

    // Configuration registers.
    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_high_reg;
    logic              case_fold_reg;

    // Sequencer and message state.
    sip_state_t        state_reg, state_next;
    logic [1:0]        round_reg, round_next;
    logic              tail_pend_reg, tail_pend_next;
    logic              in_msg_reg, in_msg_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    // Datapath.
    lanes_t            lanes_reg, lanes_next;
    logic [WORD_W-1:0] msg_reg, msg_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] hash_reg, hash_next;

    // Decoded control.
    logic              s_fire;
    logic              out_free;
    logic              round_done;
    logic              final_done;

    // Input decode.
    logic [WORD_W-1:0]  word_in;
    logic [COUNT_W-1:0] count_sat;
    logic               short_last;
    logic [LEN_W-1:0]   len_after;
    logic [WORD_W-1:0]  first_block;
    lanes_t             lanes_base;
    lanes_t             rnd;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hash_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Folding is sampled per word; the count saturates at eight on a last word.
    assign word_in    = case_fold_reg ? fold_word(s_tdata[WORD_W-1:0]) : s_tdata[WORD_W-1:0];
    assign count_sat  = s_tdata[WORD_W+3] ? FULL_COUNT : s_tdata[WORD_W +: COUNT_W];
    assign short_last = s_tlast && (count_sat != FULL_COUNT);

    always_comb begin
        logic [LEN_W-1:0] len_base;
        len_base = in_msg_reg ? len_reg : '0;
        if (s_tlast) begin
            len_after = len_base + {{(LEN_W-COUNT_W){1'b0}}, count_sat};
        end else begin
            len_after = len_base + WORD_BYTES;
        end
    end

    // A short last word goes straight in as the tail block with the length on top.
    assign first_block = short_last ?
        (keep_bytes(word_in, count_sat) | {len_after, {(WORD_W-LEN_W){1'b0}}}) : word_in;

    // The key is sampled only when a message begins.
    always_comb begin
        if (in_msg_reg) begin
            lanes_base = lanes_reg;
        end else begin
            lanes_base.a = INIT_A ^ key_low_reg;
            lanes_base.b = INIT_B ^ key_high_reg;
            lanes_base.c = INIT_C ^ key_low_reg;
            lanes_base.d = INIT_D ^ key_high_reg;
        end
    end

    // The shared round unit.
    assign rnd = sip_round(lanes_reg);

    // Sequencer outputs.
    always_comb begin
        s_tready   = 1'b0;
        round_done = 1'b0;
        final_done = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready   = 1'b1;
            ST_WORD:  round_done = (round_reg == 2'd1);
            ST_TAIL:  round_done = (round_reg == 2'd1);
            ST_FINAL: final_done = (round_reg == 2'd3) && out_free;
            default:  s_tready   = 1'b0;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        tail_pend_next = tail_pend_reg;
        in_msg_next    = in_msg_reg;
        len_next       = len_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    round_next     = 2'd0;
                    len_next       = len_after;
                    in_msg_next    = !s_tlast;
                    tail_pend_next = s_tlast && !short_last;
                    state_next     = short_last ? ST_TAIL : ST_WORD;
                end
            end
            ST_WORD: begin
                round_next = round_reg + 2'd1;
                if (round_done) begin
                    round_next = 2'd0;
                    state_next = tail_pend_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                round_next = round_reg + 2'd1;
                if (round_done) begin
                    round_next = 2'd0;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (round_reg != 2'd3) begin
                    round_next = round_reg + 2'd1;
                end else if (final_done) begin
                    round_next = 2'd0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Lane datapath around the round unit.
    always_comb begin
        lanes_next   = lanes_reg;
        msg_next     = msg_reg;
        hash_next    = hash_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    lanes_next   = lanes_base;
                    lanes_next.d = lanes_base.d ^ first_block;
                    msg_next     = first_block;
                end
            end
            ST_WORD: begin
                lanes_next = rnd;
                if (round_done) begin
                    lanes_next.a = rnd.a ^ msg_reg;
                    if (tail_pend_reg) begin
                        // Eight valid bytes: the tail block holds only the length.
                        msg_next     = {len_reg, {(WORD_W-LEN_W){1'b0}}};
                        lanes_next.d = rnd.d ^ {len_reg, {(WORD_W-LEN_W){1'b0}}};
                    end
                end
            end
            ST_TAIL: begin
                lanes_next = rnd;
                if (round_done) begin
                    lanes_next.a = rnd.a ^ msg_reg;
                    lanes_next.c = rnd.c ^ FINAL_XOR;
                end
            end
            ST_FINAL: begin
                if (round_reg != 2'd3 || final_done) begin
                    lanes_next = rnd;
                end
                if (final_done) begin
                    hash_next    = rnd.a ^ rnd.b ^ rnd.c ^ rnd.d;
                    m_valid_next = 1'b1;
                end
            end
            default: lanes_next = lanes_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= 2'd0;
            tail_pend_reg <= 1'b0;
            in_msg_reg    <= 1'b0;
            len_reg       <= '0;
            m_valid_reg   <= 1'b0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            case_fold_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            tail_pend_reg <= tail_pend_next;
            in_msg_reg    <= in_msg_next;
            len_reg       <= len_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_KEY_LOW:   key_low_reg   <= cfg_wr_data;
                    CFG_KEY_HIGH:  key_high_reg  <= cfg_wr_data;
                    CFG_CASE_FOLD: case_fold_reg <= cfg_wr_data[0];
                    default:       case_fold_reg <= case_fold_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
        msg_reg   <= msg_next;
        hash_reg  <= hash_next;
    end

endmodule
